@@ rtl/core/rnp_pkg.sv @@
// ----------------------------------------------------------------------------
// rnp_pkg
// Shared types and constants of the radix number parser: character codes,
// radix values, result status codes and the per-string state record.
// ----------------------------------------------------------------------------
package rnp_pkg;

	localparam int RadixWidth = 6;
	localparam int ValueWidth = 32;
	localparam int ConsumedWidth = 16;

	// Character codes
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_X = 8'h78;
	localparam logic [7:0] CH_O = 8'h6F;

	// Radix values
	localparam logic [RadixWidth-1:0] RADIX_DEFAULT = 6'd10;
	localparam logic [RadixWidth-1:0] RADIX_HEX = 6'd16;
	localparam logic [RadixWidth-1:0] RADIX_OCT = 6'd8;
	localparam logic [RadixWidth-1:0] LETTER_BASE = 6'd10;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_INVALID = 2'd2,
		ST_RANGE   = 2'd3
	} status_t;

	// Per-string parse state (the character count travels on its own)
	typedef struct packed {
		logic [ValueWidth-1:0] acc;
		logic                  saw_zero;
		logic [RadixWidth-1:0] radix;
		logic                  skipping;
	} parse_state_t;

	typedef struct packed {
		logic [ValueWidth-1:0]    value;
		status_t                  status;
		logic [ConsumedWidth-1:0] consumed;
	} result_t;

endpackage

@@ rtl/core/rnp_if.sv @@
// ----------------------------------------------------------------------------
// rnp_if
// Valid/ready channel interfaces of the radix number parser: character
// input, result output and the radix configuration write channel.
// ----------------------------------------------------------------------------
interface rnp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;

	modport source (output valid, output ch, input ready);
	modport sink (input valid, input ch, output ready);
endinterface

interface rnp_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] value;
	logic [1:0]  status;
	logic [15:0] consumed;

	modport source (output valid, output value, output status, output consumed, input ready);
	modport sink (input valid, input value, input status, input consumed, output ready);
endinterface

interface rnp_cfg_if;
	logic       valid;
	logic       ready;
	logic [5:0] requested_radix;

	modport source (output valid, output requested_radix, input ready);
	modport sink (input valid, input requested_radix, output ready);
endinterface

@@ rtl/core/rnp_step.sv @@
// ----------------------------------------------------------------------------
// rnp_step
// Single-character parse step: decodes the byte, picks the radix in force,
// does the multiply-add and works out the next state and any result.
// ----------------------------------------------------------------------------
module rnp_step #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic [7:0]                        ch,
	input  rnp_pkg::parse_state_t             st,
	input  logic [COUNT_WIDTH-1:0]            count,
	input  logic [rnp_pkg::RadixWidth-1:0]    req_radix,
	output rnp_pkg::parse_state_t             st_next,
	output logic [COUNT_WIDTH-1:0]            count_next,
	output logic                              emit,
	output rnp_pkg::result_t                  res
);

	logic                             at_start;
	logic [rnp_pkg::RadixWidth-1:0]   eff_radix;
	logic                             is_num;
	logic                             is_lower;
	logic                             is_upper;
	logic [rnp_pkg::RadixWidth-1:0]   digit;
	logic [COUNT_WIDTH-1:0]           count_inc;
	logic [rnp_pkg::ValueWidth-1:0]   mac;
	logic [31:0]                      count_ext;
	rnp_pkg::status_t                 status;

	// Latch radix from config at string start
	assign at_start = (count == '0) && !st.saw_zero;
	assign eff_radix = !at_start ? st.radix :
		(req_radix == '0) ? rnp_pkg::RADIX_DEFAULT : req_radix;

	// Decode the character class and digit value
	assign is_num = (ch >= rnp_pkg::CH_ZERO) && (ch <= rnp_pkg::CH_NINE);
	assign is_lower = (ch >= rnp_pkg::CH_LOWER_A) && (ch <= rnp_pkg::CH_LOWER_Z);
	assign is_upper = (ch >= rnp_pkg::CH_UPPER_A) && (ch <= rnp_pkg::CH_UPPER_Z);

	always_comb begin
		digit = '0;
		if (is_num) begin
			digit = rnp_pkg::RadixWidth'(ch - rnp_pkg::CH_ZERO);
		end else if (is_lower) begin
			digit = rnp_pkg::RadixWidth'(ch - rnp_pkg::CH_LOWER_A) + rnp_pkg::LETTER_BASE;
		end else if (is_upper) begin
			digit = rnp_pkg::RadixWidth'(ch - rnp_pkg::CH_UPPER_A) + rnp_pkg::LETTER_BASE;
		end
	end

	// Saturating count and wrapping multiply-add
	assign count_inc = (count == '1) ? count : count + COUNT_WIDTH'(1);
	assign mac = rnp_pkg::ValueWidth'(st.acc * rnp_pkg::ValueWidth'(eff_radix))
		+ rnp_pkg::ValueWidth'(digit);

	// Next state and result
	always_comb begin
		st_next = st;
		count_next = count;
		emit = 1'b0;
		status = rnp_pkg::ST_OK;
		if (st.skipping) begin
			if (ch == rnp_pkg::CH_NUL) begin
				st_next.skipping = 1'b0;
				st_next.acc = '0;
				st_next.saw_zero = 1'b0;
				count_next = '0;
			end
		end else begin
			st_next.radix = eff_radix;
			if (ch == rnp_pkg::CH_NUL) begin
				emit = 1'b1;
				status = (count == '0) ? rnp_pkg::ST_EMPTY : rnp_pkg::ST_OK;
				st_next.acc = '0;
				st_next.saw_zero = 1'b0;
				count_next = '0;
			end else if ((count == '0) && (ch == rnp_pkg::CH_ZERO)) begin
				st_next.saw_zero = 1'b1;
				count_next = count_inc;
			end else if (st.saw_zero && (count == COUNT_WIDTH'(1)) && (ch == rnp_pkg::CH_X)) begin
				st_next.radix = rnp_pkg::RADIX_HEX;
				count_next = count_inc;
			end else if (st.saw_zero && (count == COUNT_WIDTH'(1)) && (ch == rnp_pkg::CH_O)) begin
				st_next.radix = rnp_pkg::RADIX_OCT;
				count_next = count_inc;
			end else if (!(is_num || is_lower || is_upper)) begin
				emit = 1'b1;
				status = rnp_pkg::ST_INVALID;
				st_next.acc = '0;
				st_next.saw_zero = 1'b0;
				st_next.skipping = 1'b1;
				count_next = '0;
			end else if (digit >= eff_radix) begin
				emit = 1'b1;
				status = rnp_pkg::ST_RANGE;
				st_next.acc = '0;
				st_next.saw_zero = 1'b0;
				st_next.skipping = 1'b1;
				count_next = '0;
			end else begin
				st_next.acc = mac;
				count_next = count_inc;
			end
		end
	end

	// Report the state as it stood before this character
	assign count_ext = 32'(count);
	assign res.value = st.acc;
	assign res.status = status;
	assign res.consumed = count_ext[rnp_pkg::ConsumedWidth-1:0];

endmodule

@@ rtl/core/radix_number_parser_unit.sv @@
// ----------------------------------------------------------------------------
// radix_number_parser_unit
// Parses an unsigned integer from a NUL-terminated byte stream, with an
// optional 0x / 0o prefix and a configurable default radix.
// ----------------------------------------------------------------------------
// Usage:
//   chars   : one character byte per item; a zero byte ends the string.
//   results : one item per string (value, status, consumed), given at the
//             terminator or at the first bad character; after an error the
//             rest of the string up to its zero byte is dropped silently.
//   cfg     : writes requested_radix (0 selects ten); always ready, takes
//             effect at the next string start. Write only while idle.
// Timing: a character enters the input register on accept and is parsed from
//   there by the single 32-bit multiply-add by the radix; the result register
//   loads at the end of the cycle in which that character advances, and the
//   result is shown from that register. One character per cycle is sustained,
//   except while the stall below holds a character in the input register.
// Stall: while a result waits untaken, characters that produce no result
//   still flow; a character that would produce a second result holds in the
//   input register and input ready drops until the result is taken.
// Reset: clears all parse state, the radix register to zero (ten) and both
//   valid flags; no clearing pass is needed.
// ----------------------------------------------------------------------------
module radix_number_parser_unit #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	rnp_cfg_if.sink       cfg,
	rnp_char_if.sink      chars,
	rnp_result_if.source  results
);

	logic [7:0]                      ch_s1;
	logic                            valid_s1;
	rnp_pkg::parse_state_t           st_q;
	logic [COUNT_WIDTH-1:0]          count_q;
	logic [rnp_pkg::RadixWidth-1:0]  req_radix_q;
	rnp_pkg::result_t                res_q;
	logic                            out_valid_q;

	rnp_pkg::parse_state_t           st_next;
	logic [COUNT_WIDTH-1:0]          count_next;
	logic                            emit;
	rnp_pkg::result_t                res;
	logic                            out_free;
	logic                            advance;
	logic                            accept;

	rnp_step #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_step (
		.ch         (ch_s1),
		.st         (st_q),
		.count      (count_q),
		.req_radix  (req_radix_q),
		.st_next    (st_next),
		.count_next (count_next),
		.emit       (emit),
		.res        (res)
	);

	// Handshake control
	assign out_free = !out_valid_q || results.ready;
	assign advance = valid_s1 && (!emit || out_free);
	assign chars.ready = !valid_s1 || advance;
	assign accept = chars.valid && chars.ready;
	assign cfg.ready = 1'b1;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_radix_q <= '0;
		end else if (cfg.valid) begin
			req_radix_q <= cfg.requested_radix;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_s1 <= chars.ch;
		end
	end

	// Parse state: advance once per processed character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.acc <= '0;
			st_q.saw_zero <= 1'b0;
			st_q.radix <= rnp_pkg::RADIX_DEFAULT;
			st_q.skipping <= 1'b0;
			count_q <= '0;
		end else if (advance) begin
			st_q <= st_next;
			count_q <= count_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= res;
		end
	end

	assign results.valid = out_valid_q;
	assign results.value = res_q.value;
	assign results.status = res_q.status;
	assign results.consumed = res_q.consumed;

endmodule

@@ rtl/core/rnp_checker.sv @@
// ----------------------------------------------------------------------------
// rnp_checker
// Port-level checks of the radix number parser, bound to the top level.
// ----------------------------------------------------------------------------
module rnp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] value,
	input logic [1:0]  status,
	input logic [15:0] consumed
);

	// Hold a stalled result steady
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value) && $stable(status)
			&& $stable(consumed))
	else $error("stalled result changed");

	// Drop a result only after it was taken
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
	else $error("result dropped without being taken");

	// Accept input whenever the output side is not stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
	else $error("input stalled while output is free");

	// Report an empty string with zero value and zero count
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == rnp_pkg::ST_EMPTY) |-> (value == '0) && (consumed == '0))
	else $error("empty-string result carries data");

endmodule

bind radix_number_parser_unit rnp_checker u_rnp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (chars.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.value     (results.value),
	.status    (results.status),
	.consumed  (results.consumed)
);

@@ dv/radix_number_parser_unit_test.sv @@
// ----------------------------------------------------------------------------
// radix_number_parser_unit_test
// Self-checking testbench of the radix number parser. A scripted run covers
// the empty string, bare prefixes, range and invalid-character errors,
// dropped bytes after an error and the radix extremes. A random run follows
// over several radix settings, with a long receiver hold-off. Every result
// is compared against an in-bench model of the parser or a typed-in result.
// ----------------------------------------------------------------------------
module radix_number_parser_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COUNT_WIDTH = 16;
	localparam int IDLE_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 6;
	localparam int PHASE_ITEMS = 60;
	localparam int MAX_REPORTS = 10;
	localparam int NUM_ROWS = 31;

	localparam rnp_pkg::result_t NONE_DUE = '0;

	typedef enum bit {
		ROW_CHAR,
		ROW_RADIX
	} row_kind_t;

	typedef struct packed {
		row_kind_t        kind;
		logic [7:0]       data;
		bit               typed;
		rnp_pkg::result_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rnp_cfg_if    cfg_bus ();
	rnp_char_if   char_bus ();
	rnp_result_if result_bus ();

	radix_number_parser_unit #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.chars  (char_bus),
		.results(result_bus)
	);

	always #5 clk = ~clk;

	// Scripted strings; results typed in where they are obvious
	row_t script [NUM_ROWS] = '{
		'{ROW_CHAR,  rnp_pkg::CH_NUL,            1'b1, {32'd0, rnp_pkg::ST_EMPTY, 16'd0}},
		'{ROW_CHAR,  rnp_pkg::CH_ZERO,           1'b0, NONE_DUE},
		'{ROW_CHAR,  rnp_pkg::CH_X,              1'b0, NONE_DUE},
		'{ROW_CHAR,  rnp_pkg::CH_NUL,            1'b1, {32'd0, rnp_pkg::ST_OK, 16'd2}},
		'{ROW_CHAR,  rnp_pkg::CH_ZERO,           1'b0, NONE_DUE},
		'{ROW_CHAR,  rnp_pkg::CH_O,              1'b0, NONE_DUE},
		'{ROW_CHAR,  rnp_pkg::CH_ZERO + 8'd7,    1'b0, NONE_DUE},
		'{ROW_CHAR,  rnp_pkg::CH_NUL,            1'b0, NONE_DUE},
		'{ROW_CHAR,  rnp_pkg::CH_NINE,           1'b0, NONE_DUE},
		'{ROW_CHAR,  rnp_pkg::CH_UPPER_Z,        1'b1, {32'd9, rnp_pkg::ST_RANGE, 16'd1}},
		'{ROW_CHAR,  8'hFF,                      1'b0, NONE_DUE},
		'{ROW_CHAR,  rnp_pkg::CH_NUL,            1'b0, NONE_DUE},
		'{ROW_CHAR,  rnp_pkg::CH_ZERO + 8'd5,    1'b0, NONE_DUE},
		'{ROW_CHAR,  8'hFF,                      1'b1, {32'd5, rnp_pkg::ST_INVALID, 16'd1}},
		'{ROW_CHAR,  rnp_pkg::CH_NUL,            1'b0, NONE_DUE},
		'{ROW_RADIX, 8'd36,                      1'b0, NONE_DUE},
		'{ROW_CHAR,  rnp_pkg::CH_LOWER_Z,        1'b0, NONE_DUE},
		'{ROW_CHAR,  rnp_pkg::CH_UPPER_Z,        1'b0, NONE_DUE},
		'{ROW_CHAR,  rnp_pkg::CH_NUL,            1'b0, NONE_DUE},
		'{ROW_RADIX, 8'd1,                       1'b0, NONE_DUE},
		'{ROW_CHAR,  rnp_pkg::CH_ZERO,           1'b0, NONE_DUE},
		'{ROW_CHAR,  rnp_pkg::CH_ZERO,           1'b0, NONE_DUE},
		'{ROW_CHAR,  rnp_pkg::CH_NUL,            1'b0, NONE_DUE},
		'{ROW_CHAR,  rnp_pkg::CH_ZERO + 8'd1,    1'b1, {32'd0, rnp_pkg::ST_RANGE, 16'd0}},
		'{ROW_CHAR,  rnp_pkg::CH_NUL,            1'b0, NONE_DUE},
		'{ROW_RADIX, 8'd63,                      1'b0, NONE_DUE},
		'{ROW_CHAR,  rnp_pkg::CH_UPPER_Z,        1'b0, NONE_DUE},
		'{ROW_CHAR,  rnp_pkg::CH_LOWER_Z,        1'b0, NONE_DUE},
		'{ROW_CHAR,  rnp_pkg::CH_LOWER_A + 8'd5, 1'b0, NONE_DUE},
		'{ROW_CHAR,  rnp_pkg::CH_NUL,            1'b0, NONE_DUE},
		'{ROW_RADIX, 8'd0,                       1'b0, NONE_DUE}
	};

	// Radix per random phase; a negative entry picks one at random
	int radix_plan [7] = '{0, 16, 2, 36, 63, 1, -1};

	// Parser model state
	logic [31:0]                     acc_q = '0;
	logic [COUNT_WIDTH-1:0]          count_q = '0;
	bit                              zero_seen = 1'b0;
	logic [rnp_pkg::RadixWidth-1:0]  radix_act = rnp_pkg::RADIX_DEFAULT;
	bit                              skip_rest = 1'b0;
	logic [rnp_pkg::RadixWidth-1:0]  radix_req = '0;

	rnp_pkg::result_t results_due [$];
	int      mismatches = 0;
	int      parsed_items = 0;
	int      burst_left = 0;
	bit      hold_request = 1'b0;

	// Report the parsed number and reset the per-string state
	function automatic void close_string(input rnp_pkg::status_t s,
			output rnp_pkg::result_t res);
		res.value = acc_q;
		res.status = s;
		res.consumed = 16'(count_q);
		acc_q = '0;
		count_q = '0;
		zero_seen = 1'b0;
	endfunction

	function automatic void bump_count();
		if (count_q != '1) begin
			count_q = count_q + 1'b1;
		end
	endfunction

	// Advance the parser model by one character; return 1 when a result is due
	function automatic bit parse_char(input logic [7:0] c, output rnp_pkg::result_t res);
		logic [7:0] digit;
		res = NONE_DUE;
		if (skip_rest) begin
			if (c == rnp_pkg::CH_NUL) begin
				skip_rest = 1'b0;
				close_string(rnp_pkg::ST_OK, res);
				res = NONE_DUE;
			end
			return 1'b0;
		end
		// latch the radix at string start
		if (count_q == '0 && !zero_seen) begin
			radix_act = (radix_req == '0) ? rnp_pkg::RADIX_DEFAULT : radix_req;
		end
		if (c == rnp_pkg::CH_NUL) begin
			close_string((count_q == '0) ? rnp_pkg::ST_EMPTY : rnp_pkg::ST_OK, res);
			return 1'b1;
		end
		if (count_q == '0 && c == rnp_pkg::CH_ZERO) begin
			zero_seen = 1'b1;
			bump_count();
			return 1'b0;
		end
		if (zero_seen && count_q == 1 && (c == rnp_pkg::CH_X || c == rnp_pkg::CH_O)) begin
			radix_act = (c == rnp_pkg::CH_X) ? rnp_pkg::RADIX_HEX : rnp_pkg::RADIX_OCT;
			bump_count();
			return 1'b0;
		end
		if (c >= rnp_pkg::CH_ZERO && c <= rnp_pkg::CH_NINE) begin
			digit = c - rnp_pkg::CH_ZERO;
		end else if (c >= rnp_pkg::CH_LOWER_A && c <= rnp_pkg::CH_LOWER_Z) begin
			digit = c - rnp_pkg::CH_LOWER_A + 8'(rnp_pkg::LETTER_BASE);
		end else if (c >= rnp_pkg::CH_UPPER_A && c <= rnp_pkg::CH_UPPER_Z) begin
			digit = c - rnp_pkg::CH_UPPER_A + 8'(rnp_pkg::LETTER_BASE);
		end else begin
			close_string(rnp_pkg::ST_INVALID, res);
			skip_rest = 1'b1;
			return 1'b1;
		end
		if (digit >= {2'b00, radix_act}) begin
			close_string(rnp_pkg::ST_RANGE, res);
			skip_rest = 1'b1;
			return 1'b1;
		end
		acc_q = acc_q * {26'd0, radix_act} + {24'd0, digit};
		bump_count();
		return 1'b0;
	endfunction

	// Pick a character that is a legal digit in radix r
	function automatic logic [7:0] digit_char(input logic [rnp_pkg::RadixWidth-1:0] r);
		int top;
		int d;
		top = (r > 36) ? 36 : int'(r);
		d = $urandom_range(0, top - 1);
		if (d < 10) begin
			return rnp_pkg::CH_ZERO + 8'(d);
		end
		return (($urandom_range(0, 1) == 1) ? rnp_pkg::CH_LOWER_A : rnp_pkg::CH_UPPER_A)
			+ 8'(d - 10);
	endfunction

	// Offer one character item in bursts; predict on accept
	task automatic send_char(input logic [7:0] c, input bit typed = 1'b0,
			input rnp_pkg::result_t want = NONE_DUE);
		int gap;
		bit skipped;
		bit has;
		rnp_pkg::result_t got;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				char_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		char_bus.valid <= 1'b1;
		char_bus.ch <= c;
		do @(posedge clk); while (!char_bus.ready);
		skipped = skip_rest;
		has = parse_char(c, got);
		if (typed) begin
			results_due.push_back(want);
		end else if (has) begin
			results_due.push_back(got);
		end
		if (!skipped) begin
			parsed_items++;
		end
	endtask

	// Drop valid and wait until every result is out and the pipe is empty
	task automatic settle_parser();
		char_bus.valid <= 1'b0;
		burst_left = 0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_radix(input logic [rnp_pkg::RadixWidth-1:0] r);
		settle_parser();
		cfg_bus.valid <= 1'b1;
		cfg_bus.requested_radix <= r;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		radix_req = r;
	endtask

	// Mostly well-formed strings, some broken ones, some noise
	task automatic send_random_string();
		int kind;
		int len;
		logic [rnp_pkg::RadixWidth-1:0] r;
		r = (radix_req == '0) ? rnp_pkg::RADIX_DEFAULT : radix_req;
		kind = $urandom_range(0, 99);
		if (kind < 70) begin
			case ($urandom_range(0, 3))
				0: begin
					send_char(rnp_pkg::CH_ZERO);
					send_char(rnp_pkg::CH_X);
					r = rnp_pkg::RADIX_HEX;
				end
				1: begin
					send_char(rnp_pkg::CH_ZERO);
					send_char(rnp_pkg::CH_O);
					r = rnp_pkg::RADIX_OCT;
				end
				default: ;
			endcase
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 12);
			repeat (len) send_char(digit_char(r));
		end else if (kind < 85) begin
			repeat ($urandom_range(0, 6)) send_char(digit_char(r));
			send_char(8'($urandom_range(1, 255)));
			repeat ($urandom_range(0, 4)) send_char(8'($urandom_range(1, 255)));
		end else begin
			repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(0, 255)));
		end
		send_char(rnp_pkg::CH_NUL);
	endtask

	// Receiver: ready on a rotating mask, plus one long hold-off on request
	initial begin : receiver
		logic [15:0] mask;
		int hold_left;
		int slot;
		mask = '1;
		hold_left = 0;
		slot = 0;
		result_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				result_bus.ready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
				result_bus.ready <= 1'b0;
			end else begin
				if (slot == 0) begin
					case ($urandom_range(0, 3))
						0: mask = '1;
						1: mask = 16'($urandom);
						2: mask = 16'($urandom) | 16'($urandom);
						default: mask = 16'($urandom) & 16'($urandom);
					endcase
					mask[0] = 1'b1;
				end
				result_bus.ready <= mask[4'(slot)];
				slot = (slot + 1) % 64;
			end
		end
	end

	// Compare each result item with the oldest one due
	always @(posedge clk) begin : check_results
		rnp_pkg::result_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("unexpected result: value %0d status %0d consumed %0d",
						result_bus.value, result_bus.status, result_bus.consumed);
				end
			end else begin
				want = results_due.pop_front();
				if (result_bus.value !== want.value || result_bus.status !== want.status
						|| result_bus.consumed !== want.consumed) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("result mismatch: expected value %0d status %0d consumed %0d,",
							want.value, want.status, want.consumed);
						$display("  got value %0d status %0d consumed %0d",
							result_bus.value, result_bus.status, result_bus.consumed);
					end
				end
			end
		end
	end

	// End the run when no item moves on any channel for too long
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((char_bus.valid && char_bus.ready) || (result_bus.valid && result_bus.ready)
					|| (cfg_bus.valid && cfg_bus.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stimulus
		int phase_start;
		logic [rnp_pkg::RadixWidth-1:0] r;
		char_bus.valid <= 1'b0;
		char_bus.ch <= '0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.requested_radix <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the scripted rows
		foreach (script[i]) begin
			if (script[i].kind == ROW_RADIX) begin
				write_radix(script[i].data[rnp_pkg::RadixWidth-1:0]);
			end else begin
				send_char(script[i].data, script[i].typed, script[i].want);
			end
		end

		// random phases, one radix each; hold off the receiver in the second
		foreach (radix_plan[p]) begin
			r = (radix_plan[p] < 0) ? rnp_pkg::RadixWidth'($urandom_range(0, 63))
				: rnp_pkg::RadixWidth'(radix_plan[p]);
			write_radix(r);
			if (p == 1) begin
				hold_request = 1'b1;
			end
			phase_start = parsed_items;
			while (parsed_items - phase_start < PHASE_ITEMS) send_random_string();
		end

		settle_parser();
		if (mismatches == 0 && results_due.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/rnp_pkg.sv
rtl/core/rnp_if.sv
rtl/core/rnp_step.sv
rtl/core/radix_number_parser_unit.sv
rtl/core/rnp_checker.sv
dv/radix_number_parser_unit_test.sv
